// ----- sv/sltp_pkg.sv -----
// Package: payload types, letter codes and phoneme codes of the letter-to-phoneme block
`default_nettype none
package sltp_pkg;

	localparam logic [7:0] A_AC  = 8'd225;
	localparam logic [7:0] E_AC  = 8'd233;
	localparam logic [7:0] I_AC  = 8'd237;
	localparam logic [7:0] O_AC  = 8'd243;
	localparam logic [7:0] U_AC  = 8'd250;
	localparam logic [7:0] N_TL  = 8'd241;
	localparam logic [7:0] U_DI  = 8'd252;
	localparam logic [7:0] SPACE = 8'd32;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_LONG    = 2'd2;

	localparam logic [4:0] P_SIL = 5'd0,  P_B  = 5'd1,  P_D  = 5'd2,  P_F  = 5'd3;
	localparam logic [4:0] P_G   = 5'd4,  P_K  = 5'd5,  P_L  = 5'd6,  P_M  = 5'd7;
	localparam logic [4:0] P_N   = 5'd8,  P_P  = 5'd9,  P_S  = 5'd10, P_T  = 5'd11;
	localparam logic [4:0] P_W   = 5'd12, P_Y  = 5'd13, P_Z  = 5'd14, P_AA = 5'd15;
	localparam logic [4:0] P_BB  = 5'd16, P_CH = 5'd17, P_DD = 5'd18, P_EY = 5'd19;
	localparam logic [4:0] P_GG  = 5'd20, P_HH = 5'd21, P_IY = 5'd22, P_NY = 5'd23;
	localparam logic [4:0] P_OW  = 5'd24, P_RR = 5'd25, P_RX = 5'd26, P_UW = 5'd27;

	localparam int QDEPTH = 4;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_word;
	} in_word_t;

	typedef struct packed {
		logic [4:0] phoneme;
		logic       last;
		logic [1:0] status;
		logic [8:0] phoneme_count;
	} out_word_t;

	// One letter job for the back end: letter, its lookahead, and framing marks.
	typedef struct packed {
		logic       lead_sil;
		logic       has_letter;
		logic [7:0] c;
		logic [7:0] nx;
		logic [7:0] nn;
		logic       close;
	} job_t;

	// What one letter sounds as.
	typedef struct packed {
		logic       unknown;
		logic [1:0] k;
		logic [4:0] ph0;
		logic [4:0] ph1;
		logic       sk;
	} snd_t;

	// Back end steps within one job.
	typedef enum logic [1:0] {
		STEP_LEAD,
		STEP_PH0,
		STEP_PH1,
		STEP_CLOSE
	} step_t;

	function automatic logic is_vowel(input logic [7:0] v);
		return v == "a" || v == "e" || v == "i" || v == "o" || v == "u" ||
			v == A_AC || v == E_AC || v == I_AC || v == O_AC || v == U_AC;
	endfunction

	function automatic logic is_open(input logic [7:0] v);
		return v == "a" || v == "e" || v == "o" || v == A_AC || v == E_AC || v == O_AC;
	endfunction

	function automatic logic is_aou(input logic [7:0] v);
		return v == "a" || v == "u" || v == "o" || v == A_AC || v == U_AC || v == O_AC;
	endfunction

	function automatic logic is_front(input logic [7:0] v);
		return v == "e" || v == "i" || v == E_AC || v == I_AC;
	endfunction

	// Context rules for one letter.
	function automatic snd_t sound(input logic [7:0] c, input logic [7:0] nx,
		input logic [7:0] nn, input logic [7:0] pv);
		snd_t r;
		r = '{unknown: 1'b0, k: 2'd1, ph0: P_SIL, ph1: P_SIL, sk: 1'b0};
		case (c)
			"a", A_AC: r.ph0 = P_AA;
			"e", E_AC: r.ph0 = P_EY;
			"o", O_AC: begin
				r.ph0 = P_OW;
				if (nx == "u" && nn == "r") begin
					r.k = 2'd2; r.ph1 = P_W; r.sk = 1'b1;
				end
			end
			"b": r.ph0 = (pv == "m" || pv == "n" || pv == SPACE || nx == "v") ? P_B : P_BB;
			"v": r.ph0 = (pv == "n" || pv == SPACE) ? P_B : P_BB;
			"j": r.ph0 = P_HH;
			"k", "q": r.ph0 = P_K;
			"m": r.ph0 = P_M;
			"p": r.ph0 = P_P;
			"w", U_DI: r.ph0 = P_W;
			"z": r.ph0 = P_S;
			N_TL: r.ph0 = P_NY;
			U_AC: r.ph0 = P_UW;
			"h": r.k = 2'd0;
			"n": begin r.sk = (nx == "n"); r.ph0 = P_N; end
			"t": begin r.sk = (nx == "t"); r.ph0 = P_T; end
			"f": begin r.sk = (nx == "f"); r.ph0 = P_F; end
			"d": begin
				r.sk = (nx == "d");
				r.ph0 = (pv == SPACE || pv == "l" || pv == "n" || nx == "d") ? P_D : P_DD;
			end
			"r": begin
				if (pv == SPACE) r.ph0 = P_RR;
				else if (nx == "r") begin r.ph0 = P_RR; r.sk = 1'b1; end
				else r.ph0 = P_RX;
			end
			"l": begin
				if (nx == "l") begin r.ph0 = P_Y; r.sk = 1'b1; end
				else r.ph0 = P_L;
			end
			"c": begin
				if (nx == "h") r.ph0 = P_CH;
				else if (nx == "c") begin
					r.k = 2'd2; r.ph0 = P_K; r.ph1 = P_S; r.sk = 1'b1;
				end else if (nx == "y") begin
					r.k = 2'd2; r.ph0 = P_K; r.ph1 = P_IY; r.sk = 1'b1;
				end else r.ph0 = is_front(nx) ? P_S : P_K;
			end
			"x": begin
				r.k = 2'd2; r.ph0 = P_K; r.ph1 = P_S;
				r.sk = (nx == "c" && nn != "a");
			end
			"s": begin
				if (nx == "c") begin
					r.ph0 = P_S;
					r.sk = !(nn == "r" || nn == "o" || nn == "a" || nn == "u" ||
						nn == A_AC || nn == U_AC || nn == O_AC || nn == "l");
				end else if (nx == "s") begin
					r.ph0 = P_S; r.sk = 1'b1;
				end else if ((pv == O_AC && nx == "m") || nx == "t" || nx == "i" ||
					nx == SPACE || nx == "o" || nx == "a" || nx == A_AC || nx == "u" ||
					nx == "p" || nx == "e" || nx == O_AC || nx == E_AC || nx == "f" ||
					nx == "q" || nx == I_AC || nx == "h" || nx == "v" || nx == "y" ||
					nx == U_AC) begin
					r.ph0 = P_S;
				end else r.ph0 = P_Z;
			end
			"i": r.ph0 = (is_vowel(nx) || is_open(pv)) ? P_Y : P_IY;
			I_AC: r.ph0 = (nx == "e" && is_open(pv)) ? P_Y : P_IY;
			"y": r.ph0 = (pv == "t" || (pv == "n" && nx == SPACE)) ? P_IY : P_Y;
			"g": begin
				if ((pv == SPACE && !is_front(nx)) ||
					((pv == "n" || pv == "l" || pv == "s" || pv == "r" || pv == "z" ||
					pv == "b") && is_aou(nx)) ||
					nx == "m" || nx == "d" || nx == SPACE || pv == "z" || pv == "f" ||
					nx == "l" || nx == "n" || nx == "r" || nx == U_DI)
					r.ph0 = P_G;
				else if (is_front(nx)) r.ph0 = P_HH;
				else r.ph0 = P_GG;
			end
			"u": begin
				if (pv == "g") begin
					if (nx == "a" || nx == "o" || nx == "u") r.ph0 = P_W;
					else if (!is_front(nx)) r.ph0 = P_UW;
					else r.k = 2'd0;
				end else if (pv != "q") begin
					r.ph0 = (is_vowel(nx) || is_open(pv)) ? P_W : P_UW;
				end else r.k = 2'd0;
			end
			default: begin r.unknown = 1'b1; r.k = 2'd0; end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/spanish_letter_to_phoneme_top.sv -----
// Top level of the Spanish letter-to-phoneme converter
`default_nettype none
// Letters enter one word per cycle, while in_stall is low, into a front end that
// keeps the two-letter lookahead window and frames each word; letter jobs pass
// through a four-entry queue to a back end that sounds them into a single output
// register. The back end emits each phoneme in its own step, spends a step with no
// output on a letter that sounds as nothing (silent h or u, or a letter taken by a
// digraph), and emits the leading silence and the closing silence in steps of their
// own. After an end-of-word letter the front end holds in_stall while it pushes the
// rest of the word (up to two buffered letters), and it also stalls while the
// queue is full, which happens when out_stall backs up the back end. When a word
// ends in error, its remaining jobs are dropped from the queue at one per cycle
// with no result, so input up to the end-of-word mark is taken and then dropped.
// The capacity register sits at address 0.
module spanish_letter_to_phoneme_top (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [0:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  sltp_pkg::in_word_t  in_word,
	input  wire                 in_valid,
	output logic                in_stall,
	output sltp_pkg::out_word_t out_word,
	output logic                out_valid,
	input  wire                 out_stall
);
	import sltp_pkg::*;

	logic [8:0] max_q;
	job_t       fjob, qhead;
	logic       fpush, qroom, qne, qpop;

	assign pready = 1'b1;
	assign prdata = {23'd0, max_q};

	// hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_q <= 9'd64;
		else if (psel && penable && pwrite && paddr == 1'b0) max_q <= pwdata[8:0];
	end

	sltp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .in_valid(in_valid),
		.in_stall(in_stall), .job(fjob), .job_push(fpush), .q_room(qroom)
	);

	sltp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push_job(fjob), .push(fpush), .room(qroom),
		.head(qhead), .nonempty(qne), .pop(qpop)
	);

	sltp_back u_back (
		.clk(clk), .arst_n(arst_n), .max_phonemes(max_q), .head(qhead),
		.nonempty(qne), .pop(qpop), .out_word(out_word), .out_valid(out_valid),
		.out_stall(out_stall)
	);

	// hold a stalled output word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_word)))
		else $error("output word changed while stalled");
	// a word carries a status only when last
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.last) |-> out_word.status == ST_OK)
		else $error("status on non-final word");
	// the final word of a word is always a silence
	a_last_sil: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.last) |-> out_word.phoneme == P_SIL)
		else $error("final word is not silence");
	// phoneme codes stay in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.phoneme <= P_UW)
		else $error("phoneme code out of range");

endmodule
`default_nettype wire

// ----- sv/sltp_front.sv -----
// Front end: letter window and word framing; emits letter jobs
`default_nettype none
module sltp_front (
	input  wire              clk,
	input  wire              arst_n,
	input  sltp_pkg::in_word_t in_word,
	input  wire              in_valid,
	output logic             in_stall,
	output sltp_pkg::job_t   job,
	output logic             job_push,
	input  wire              q_room
);
	import sltp_pkg::*;

	// Each accepted word creates up to three jobs (flush at end of word).
	logic [7:0] la0_q, la1_q;
	logic [1:0] fill_q;
	logic       started_q;
	logic       pend_q;        // more flush jobs to emit for this input
	logic [1:0] flush_i_q;     // next window position to sound
	logic [7:0] w0_q, w1_q, w2_q;
	logic [1:0] wn_q;

	logic       acc;
	logic [7:0] fnx, fnn, fc;

	assign in_stall  = pend_q || !q_room;
	assign acc       = in_valid && !in_stall;

	always_comb begin
		fc  = (flush_i_q == 2'd0) ? w0_q : (flush_i_q == 2'd1) ? w1_q : w2_q;
		fnx = ({1'b0, flush_i_q} + 3'd1 < {1'b0, wn_q}) ?
			((flush_i_q == 2'd0) ? w1_q : w2_q) : SPACE;
		fnn = ({1'b0, flush_i_q} + 3'd2 < {1'b0, wn_q}) ? w2_q : SPACE;
	end

	always_comb begin
		job      = '0;
		job_push = 1'b0;
		if (pend_q) begin
			if (q_room) begin
				job_push       = 1'b1;
				job.has_letter = 1'b1;
				job.c          = fc;
				job.nx         = fnx;
				job.nn         = fnn;
				job.close      = ({1'b0, flush_i_q} + 3'd1 == {1'b0, wn_q});
			end
		end else if (acc) begin
			job.lead_sil = !started_q;
			if (in_word.end_of_word) begin
				job_push       = 1'b1;
				job.has_letter = 1'b1;
				job.c          = (fill_q == 2'd0) ? in_word.symbol : la0_q;
				job.nx         = (fill_q == 2'd0) ? SPACE :
					(fill_q == 2'd1) ? in_word.symbol : la1_q;
				job.nn         = (fill_q == 2'd2) ? in_word.symbol : SPACE;
				job.close      = (fill_q == 2'd0);
			end else if (fill_q == 2'd2) begin
				job_push       = 1'b1;
				job.has_letter = 1'b1;
				job.c          = la0_q;
				job.nx         = la1_q;
				job.nn         = in_word.symbol;
			end else if (!started_q) begin
				job_push       = 1'b1;  // leading silence alone
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= 2'd0;
			started_q <= 1'b0;
			pend_q    <= 1'b0;
			flush_i_q <= 2'd0;
			wn_q      <= 2'd0;
		end else begin
			if (pend_q) begin
				if (q_room) begin
					flush_i_q <= flush_i_q + 2'd1;
					if ({1'b0, flush_i_q} + 3'd1 == {1'b0, wn_q}) pend_q <= 1'b0;
				end
			end else if (acc) begin
				started_q <= 1'b1;
				if (in_word.end_of_word) begin
					fill_q    <= 2'd0;
					started_q <= 1'b0;
					wn_q      <= fill_q + 2'd1;
					flush_i_q <= 2'd1;
					pend_q    <= (fill_q != 2'd0);
				end else if (fill_q != 2'd2) begin
					fill_q <= fill_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!pend_q && acc) begin
			w0_q <= (fill_q == 2'd0) ? in_word.symbol : la0_q;
			w1_q <= (fill_q == 2'd1) ? in_word.symbol : la1_q;
			w2_q <= in_word.symbol;
			if (!in_word.end_of_word) begin
				if (fill_q == 2'd2) begin
					la0_q <= la1_q;
					la1_q <= in_word.symbol;
				end else if (fill_q == 2'd1) la1_q <= in_word.symbol;
				else la0_q <= in_word.symbol;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/sltp_queue.sv -----
// Short job queue between the front end and the back end
`default_nettype none
module sltp_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  sltp_pkg::job_t push_job,
	input  wire            push,
	output logic           room,
	output sltp_pkg::job_t head,
	output logic           nonempty,
	input  wire            pop
);
	import sltp_pkg::*;

	localparam int AW = $clog2(QDEPTH);

	job_t        mem_q [QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign room     = (cnt_q < (AW+1)'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_job;
	end

endmodule
`default_nettype wire

// ----- sv/sltp_back.sv -----
// Back end: sounds letter jobs and emits phoneme words through an output register
`default_nettype none
module sltp_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [8:0]          max_phonemes,
	input  sltp_pkg::job_t      head,
	input  wire                 nonempty,
	output logic                pop,
	output sltp_pkg::out_word_t out_word,
	output logic                out_valid,
	input  wire                 out_stall
);
	import sltp_pkg::*;

	step_t      step_q, step_d;
	logic [7:0] prev_q, prev_d;
	logic       skip_q, skip_d;
	logic [8:0] cnt_q, cnt_d;
	logic       drop_q, drop_d;    // rest of a failed word still in the queue
	logic       ov_q;
	out_word_t  ow_q;

	snd_t       s;
	step_t      cur;
	logic [8:0] cap;
	logic [8:0] cnt_inc;
	logic       free;
	out_word_t  ow_d;
	logic [1:0] fail_st;
	logic       emit, fail, letter_done;

	assign cap     = (max_phonemes == 9'd0) ? 9'd1 :
		(max_phonemes > 9'd256) ? 9'd256 : max_phonemes;
	assign free    = !ov_q || !out_stall;
	assign s       = sound(head.c, head.nx, head.nn, prev_q);
	assign cnt_inc = cnt_q + 9'd1;
	assign cur     = (step_q == STEP_LEAD && !head.lead_sil) ? STEP_PH0 : step_q;

	always_comb begin
		step_d = step_q; prev_d = prev_q; skip_d = skip_q; cnt_d = cnt_q; drop_d = drop_q;
		emit = 1'b0; fail = 1'b0; letter_done = 1'b0; pop = 1'b0;
		ow_d = '0; fail_st = ST_LONG;
		if (drop_q) begin
			// drop remaining jobs of the failed word up to its closing job
			if (nonempty) begin
				pop = 1'b1;
				if (head.close) drop_d = 1'b0;
			end
		end else if (nonempty && free) begin
			unique case (cur)
				STEP_LEAD: begin
					emit  = 1'b1;
					cnt_d = 9'd1;
					if (cap == 9'd1) fail = 1'b1;
					else if (head.has_letter) step_d = STEP_PH0;
					else pop = 1'b1;
				end
				STEP_PH0: begin
					if (skip_q) letter_done = 1'b1;
					else if (s.unknown) begin
						emit    = 1'b1;
						fail    = 1'b1;
						fail_st = ST_UNKNOWN;
					end else if (s.k == 2'd0) letter_done = 1'b1;
					else begin
						emit         = 1'b1;
						cnt_d        = cnt_inc;
						ow_d.phoneme = s.ph0;
						if (cnt_inc >= cap) fail = 1'b1;
						else if (s.k == 2'd2) step_d = STEP_PH1;
						else letter_done = 1'b1;
					end
				end
				STEP_PH1: begin
					emit         = 1'b1;
					cnt_d        = cnt_inc;
					ow_d.phoneme = s.ph1;
					if (cnt_inc >= cap) fail = 1'b1;
					else letter_done = 1'b1;
				end
				STEP_CLOSE: begin
					emit   = 1'b1;
					pop    = 1'b1;
					ow_d   = '{phoneme: P_SIL, last: 1'b1, status: ST_OK,
						phoneme_count: cnt_inc};
					step_d = STEP_LEAD;
					prev_d = SPACE;
					skip_d = 1'b0;
					cnt_d  = 9'd0;
				end
				default: ;
			endcase
			if (letter_done) begin
				prev_d = head.c;
				skip_d = skip_q ? 1'b0 : s.sk;
				if (head.close) step_d = STEP_CLOSE;
				else begin
					step_d = STEP_LEAD;
					pop    = 1'b1;
				end
			end
			if (fail) begin
				ow_d   = '{phoneme: P_SIL, last: 1'b1, status: fail_st, phoneme_count: 9'd0};
				pop    = 1'b1;
				step_d = STEP_LEAD;
				prev_d = SPACE;
				skip_d = 1'b0;
				cnt_d  = 9'd0;
				drop_d = !head.close;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_LEAD;
			prev_q <= SPACE;
			skip_q <= 1'b0;
			cnt_q  <= 9'd0;
			drop_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			step_q <= step_d;
			prev_q <= prev_d;
			skip_q <= skip_d;
			cnt_q  <= cnt_d;
			drop_q <= drop_d;
			if (emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) ow_q <= ow_d;
	end

	assign out_word  = ow_q;
	assign out_valid = ov_q;

endmodule
`default_nettype wire

// ----- dv/spanish_letter_to_phoneme_top_tb.sv -----
// Testbench: randomized word stimulus and scoreboard for the letter-to-phoneme converter
`default_nettype none
module spanish_letter_to_phoneme_top_tb;
	import sltp_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [0:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	in_word_t in_word = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	out_word_t out_word;
	logic out_valid;
	logic out_stall = 1'b0;

	spanish_letter_to_phoneme_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_word(in_word), .in_valid(in_valid), .in_stall(in_stall),
		.out_word(out_word), .out_valid(out_valid), .out_stall(out_stall)
	);

	always #6 clk = ~clk;

	// Letters waiting to be offered, and phonemes the block still owes us.
	in_word_t letter_q[$];
	out_word_t phoneme_q[$];
	int mismatches = 0;
	int cycles = 0;
	bit quiet = 1'b0;       // no idling on either side while set
	bit long_hold_req = 1'b0;

	// Shadow of the converter state.
	logic [8:0] max_ph = 9'd64;
	logic [7:0] prev_ltr;
	logic [7:0] ahead[2];
	int ahead_n;
	bit skip_ltr;
	int ph_count;
	bit in_word_flag;
	bit dropping;
	int step_results;

	function automatic bit vowel_c(logic [7:0] v);
		return v == "a" || v == "e" || v == "i" || v == "o" || v == "u" ||
			v == A_AC || v == E_AC || v == I_AC || v == O_AC || v == U_AC;
	endfunction
	function automatic bit open_c(logic [7:0] v);
		return v == "a" || v == "e" || v == "o" || v == A_AC || v == E_AC || v == O_AC;
	endfunction
	function automatic bit back_c(logic [7:0] v);
		return v == "a" || v == "u" || v == "o" || v == A_AC || v == U_AC || v == O_AC;
	endfunction
	function automatic bit front_c(logic [7:0] v);
		return v == "e" || v == "i" || v == E_AC || v == I_AC;
	endfunction

	task automatic push_phoneme(logic [4:0] ph, logic lst, logic [1:0] st, logic [8:0] n);
		out_word_t w;
		w.phoneme = ph; w.last = lst; w.status = st; w.phoneme_count = n;
		if (step_results < 8) begin
			phoneme_q.push_back(w);
			step_results++;
		end
	endtask

	task automatic count_phoneme(logic [4:0] ph, output bit ok);
		int cap;
		cap = (max_ph == 0) ? 1 : (max_ph > 256) ? 256 : max_ph;
		ph_count++;
		if (ph_count >= cap) begin
			push_phoneme(P_SIL, 1'b1, ST_LONG, 9'd0);
			ok = 1'b0;
		end else begin
			push_phoneme(ph, 1'b0, ST_OK, 9'd0);
			ok = 1'b1;
		end
	endtask

	task automatic clear_word();
		prev_ltr = SPACE; ahead_n = 0; skip_ltr = 0; ph_count = 0; in_word_flag = 0;
	endtask

	// Sound one letter given its two-letter lookahead; ok drops on an error end.
	task automatic sound_letter(logic [7:0] c, logic [7:0] nx, logic [7:0] nn, output bit ok);
		logic [4:0] ph[2];
		int k;
		bit sk;
		logic [7:0] pv;
		k = 0; sk = 0; pv = prev_ltr; ok = 1'b1;
		if (skip_ltr) begin
			skip_ltr = 0; prev_ltr = c;
			return;
		end
		case (c)
			"a", A_AC: ph[k++] = P_AA;
			"e", E_AC: ph[k++] = P_EY;
			"o", O_AC: begin
				ph[k++] = P_OW;
				if (nx == "u" && nn == "r") begin ph[k++] = P_W; sk = 1; end
			end
			"b": ph[k++] = (pv == "m" || pv == "n" || pv == SPACE || nx == "v") ? P_B : P_BB;
			"v": ph[k++] = (pv == "n" || pv == SPACE) ? P_B : P_BB;
			"j": ph[k++] = P_HH;
			"k", "q": ph[k++] = P_K;
			"m": ph[k++] = P_M;
			"p": ph[k++] = P_P;
			"w", U_DI: ph[k++] = P_W;
			"z": ph[k++] = P_S;
			N_TL: ph[k++] = P_NY;
			U_AC: ph[k++] = P_UW;
			"h": ;
			"n": begin sk = (nx == "n"); ph[k++] = P_N; end
			"t": begin sk = (nx == "t"); ph[k++] = P_T; end
			"f": begin sk = (nx == "f"); ph[k++] = P_F; end
			"d": begin
				sk = (nx == "d");
				ph[k++] = (pv == SPACE || pv == "l" || pv == "n" || nx == "d") ? P_D : P_DD;
			end
			"r": begin
				if (pv == SPACE) ph[k++] = P_RR;
				else if (nx == "r") begin ph[k++] = P_RR; sk = 1; end
				else ph[k++] = P_RX;
			end
			"l": begin
				if (nx == "l") begin ph[k++] = P_Y; sk = 1; end
				else ph[k++] = P_L;
			end
			"c": begin
				if (nx == "h") ph[k++] = P_CH;
				else if (nx == "c") begin ph[k++] = P_K; ph[k++] = P_S; sk = 1; end
				else if (nx == "y") begin ph[k++] = P_K; ph[k++] = P_IY; sk = 1; end
				else ph[k++] = front_c(nx) ? P_S : P_K;
			end
			"x": begin
				ph[k++] = P_K; ph[k++] = P_S;
				sk = (nx == "c" && nn != "a");
			end
			"s": begin
				if (nx == "c") begin
					ph[k++] = P_S;
					sk = !(nn == "r" || nn == "o" || nn == "a" || nn == "u" ||
						nn == A_AC || nn == U_AC || nn == O_AC || nn == "l");
				end else if (nx == "s") begin
					ph[k++] = P_S; sk = 1;
				end else if ((pv == O_AC && nx == "m") || nx == "t" || nx == "i" ||
					nx == SPACE || nx == "o" || nx == "a" || nx == A_AC || nx == "u" ||
					nx == "p" || nx == "e" || nx == O_AC || nx == E_AC || nx == "f" ||
					nx == "q" || nx == I_AC || nx == "h" || nx == "v" || nx == "y" ||
					nx == U_AC)
					ph[k++] = P_S;
				else ph[k++] = P_Z;
			end
			"i": ph[k++] = (vowel_c(nx) || open_c(pv)) ? P_Y : P_IY;
			I_AC: ph[k++] = (nx == "e" && open_c(pv)) ? P_Y : P_IY;
			"y": ph[k++] = (pv == "t" || (pv == "n" && nx == SPACE)) ? P_IY : P_Y;
			"g": begin
				if ((pv == SPACE && !front_c(nx)) ||
					((pv == "n" || pv == "l" || pv == "s" || pv == "r" || pv == "z" ||
					pv == "b") && back_c(nx)) ||
					nx == "m" || nx == "d" || nx == SPACE || pv == "z" || pv == "f" ||
					nx == "l" || nx == "n" || nx == "r" || nx == U_DI)
					ph[k++] = P_G;
				else if (front_c(nx)) ph[k++] = P_HH;
				else ph[k++] = P_GG;
			end
			"u": begin
				if (pv == "g") begin
					if (nx == "a" || nx == "o" || nx == "u") ph[k++] = P_W;
					else if (!front_c(nx)) ph[k++] = P_UW;
				end else if (pv != "q") begin
					ph[k++] = (vowel_c(nx) || open_c(pv)) ? P_W : P_UW;
				end
			end
			default: begin
				push_phoneme(P_SIL, 1'b1, ST_UNKNOWN, 9'd0);
				ok = 1'b0;
				return;
			end
		endcase
		for (int j = 0; j < k; j++) begin
			count_phoneme(ph[j], ok);
			if (!ok) return;
		end
		skip_ltr = sk;
		prev_ltr = c;
	endtask

	// Advance the shadow by one accepted letter and queue what it sounds as.
	task automatic predict_letter(in_word_t w);
		logic [7:0] win[3];
		logic [7:0] nx, nn;
		int n;
		bit ok;
		step_results = 0;
		ok = 1'b1;
		if (dropping) begin
			if (w.end_of_word) dropping = 0;
			return;
		end
		if (!in_word_flag) begin
			in_word_flag = 1; prev_ltr = SPACE;
			count_phoneme(P_SIL, ok);
		end
		if (ok) begin
			for (int i = 0; i < ahead_n; i++) win[i] = ahead[i];
			win[ahead_n] = w.symbol;
			n = ahead_n + 1;
			if (w.end_of_word) begin
				for (int i = 0; i < n && ok; i++) begin
					nx = (i + 1 < n) ? win[i + 1] : SPACE;
					nn = (i + 2 < n) ? win[i + 2] : SPACE;
					sound_letter(win[i], nx, nn, ok);
				end
				if (ok) begin
					push_phoneme(P_SIL, 1'b1, ST_OK, 9'(ph_count + 1));
					clear_word();
					return;
				end
			end else if (n == 3) begin
				sound_letter(win[0], win[1], win[2], ok);
				if (ok) begin
					ahead[0] = win[1]; ahead[1] = win[2]; ahead_n = 2;
				end
			end else begin
				ahead[ahead_n] = w.symbol; ahead_n = n;
			end
		end
		if (!ok) begin
			clear_word();
			if (!w.end_of_word) dropping = 1;
		end
	endtask

	// Driver: offer queued letters with random gaps; hold the word while stalled.
	int in_gap = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			predict_letter(in_word);
		if (in_valid && in_stall) begin
			// hold the stalled word
		end else if (in_gap > 0) begin
			in_gap <= in_gap - 1;
			in_valid <= 1'b0;
		end else if (letter_q.size() > 0 && arst_n) begin
			in_word <= letter_q.pop_front();
			in_valid <= 1'b1;
			if (!quiet) begin
				if ($urandom_range(0, 99) < 20) in_gap <= $urandom_range(1, 3);
				else if ($urandom_range(0, 99) < 3) in_gap <= $urandom_range(10, 40);
			end
		end else
			in_valid <= 1'b0;
	end

	// Monitor: stall at random, once for a long stretch, and score each phoneme.
	int stall_left = 0;
	bit long_hold_done = 1'b0;
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (phoneme_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected phoneme word %h", out_word);
			end else begin
				out_word_t e;
				e = phoneme_q.pop_front();
				if (out_word.phoneme !== e.phoneme || out_word.last !== e.last ||
					out_word.status !== e.status ||
					out_word.phoneme_count !== e.phoneme_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected ph=%0d last=%0b st=%0d cnt=%0d",
							e.phoneme, e.last, e.status, e.phoneme_count,
							", got ph=%0d last=%0b st=%0d cnt=%0d",
							out_word.phoneme, out_word.last, out_word.status,
							out_word.phoneme_count);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (long_hold_req && !long_hold_done) begin
			// back up the block long enough to fill its queue and stall the input
			long_hold_done <= 1'b1;
			stall_left <= 300;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < 20) begin
			stall_left <= $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < 2) begin
			stall_left <= $urandom_range(10, 50);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_letter(logic [7:0] s, logic eow);
		in_word_t w;
		w.symbol = s; w.end_of_word = eow;
		letter_q.push_back(w);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) add_letter(s[i], i == s.len() - 1);
	endtask

	// Wait until everything offered is sounded, then let the back end settle.
	task automatic wait_idle();
		while (letter_q.size() != 0 || in_valid || phoneme_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_max(logic [8:0] v);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= '0; pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		max_ph = v;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	string frags[] = '{"ch", "ll", "rr", "qu", "gu", "gue", "gui", "cc", "sc", "sca",
		"our", "xc", "xca", "nn", "tt", "ff", "dd", "ss", "cy", "mb", "nv", "ge", "ci",
		"ui", "ai", "ou", "ha", "ny", "ty", "gl", "sm"};

	// Build one word: mostly letters and digraph fragments, now and then noise.
	task automatic add_random_word(int max_len, output int n_items);
		int len;
		logic [7:0] sym[$];
		logic [7:0] extra[7] = '{A_AC, E_AC, I_AC, O_AC, U_AC, N_TL, U_DI};
		string f;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_len) : $urandom_range(1, 8);
		while (sym.size() < len) begin
			case ($urandom_range(0, 19))
				0: sym.push_back(8'($urandom_range(0, 255)));
				1, 2: sym.push_back(extra[$urandom_range(0, 6)]);
				3, 4, 5, 6, 7, 8: begin
					f = frags[$urandom_range(0, frags.size() - 1)];
					for (int i = 0; i < f.len(); i++) sym.push_back(f[i]);
				end
				default: sym.push_back(8'($urandom_range("a", "z")));
			endcase
		end
		foreach (sym[i]) add_letter(sym[i], i == sym.size() - 1);
		n_items = sym.size();
	endtask

	initial begin
		logic [8:0] caps[7] = '{9'd64, 9'd1, 9'd256, 9'd7, 9'd0, 9'd511, 9'd20};
		int sent;
		int n;
		clear_word();
		dropping = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_max(caps[0]);

		// directed: digraphs, soft c, hard g, glides, silent h and u, errors
		add_text("chorro"); add_text("llueve"); add_text("guiso");
		add_text("cerveza"); add_text("x");
		add_letter(8'd0, 1'b1);                      // unknown on the marked letter
		add_letter("a", 1'b0); add_letter(SPACE, 1'b0);  // unknown mid-word, then drop
		add_letter("b", 1'b0); add_letter(8'd255, 1'b1);
		add_letter(N_TL, 1'b0); add_letter(U_DI, 1'b0); add_letter(I_AC, 1'b1);
		wait_idle();

		sent = 0;
		foreach (caps[p]) begin
			if (p != 0) write_max(caps[p]);
			quiet = (p == 3);
			if (p == 2) long_hold_req = 1'b1;
			for (int w = 0; w < 8; w++) begin
				add_random_word((max_ph <= 20 && max_ph != 0) ? 30 : 12, n);
				sent += n;
			end
			wait_idle();
		end
		// sender pauses after about one word in four so the block drains before the next
		while (sent < 420) begin
			add_random_word(12, n);
			sent += n;
			if ($urandom_range(0, 3) == 0) wait_idle();
		end
		wait_idle();
		if (mismatches == 0 && phoneme_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
